// ===== rtl/core/a2p_pkg.sv =====
// Shared widths, fixed-point constants and pipeline types for the atan2 unit.
package a2p_pkg;

  localparam int IN_WIDTH        = 16;
  localparam int ANGLE_FRAC_BITS = 13;
  localparam int OUT_WIDTH       = 16;

  // Internal fixed-point format: Q30 unsigned ratio, signed Q30 accumulator.
  localparam int QB      = 30;
  localparam int MAG_W   = IN_WIDTH;
  localparam int REM_W   = MAG_W + 1;
  localparam int R_W     = QB + 1;
  localparam int ACC_W   = R_W + 1;
  localparam int PROD_W  = ACC_W + R_W + 1;
  localparam int UNF_W   = ACC_W + 2;
  localparam int SHIFT   = QB - ANGLE_FRAC_BITS;

  localparam int POLY_N    = 7;
  localparam int DIV_CELLS = R_W;
  localparam int MAC_CELLS = POLY_N + 1;

  localparam logic signed [ACC_W-1:0] COEF [POLY_N] = '{
    32'sd7744777,
    -32'sd37645046,
    32'sd87698811,
    -32'sd143609290,
    32'sd213208227,
    -32'sd357824448,
    32'sd1073741824
  };

  localparam logic signed [UNF_W-1:0] PI_Q30      = 34'sd3373259426;
  localparam logic signed [UNF_W-1:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam logic [UNF_W-1:0]        RND         = UNF_W'(1) << (QB - 1 - ANGLE_FRAC_BITS);
  localparam logic [UNF_W-1:0]        MAG_LIM     = UNF_W'(1) << (OUT_WIDTH - 1);

  localparam int          OUT_MAX = (2 ** (OUT_WIDTH - 1)) - 1;
  localparam longint      PI_RND  = (64'd3373259426 + (64'd1 << (QB - 1 - ANGLE_FRAC_BITS)))
                                    >> SHIFT;
  localparam int          ANGLE_BOUND = (PI_RND > OUT_MAX) ? OUT_MAX : int'(PI_RND);

  typedef struct packed {
    logic valid;
    logic zero;
    logic ybig;
    logic xneg;
    logic yneg;
  } ctl_t;

  typedef struct packed {
    logic [R_W-1:0] r;
    logic [R_W-1:0] r2;
  } aux_t;

endpackage

// ===== rtl/core/a2p_div_cell.sv =====
// One restoring-division cell: resolves one quotient bit of min/max per cycle while en_i is high.
module a2p_div_cell
  import a2p_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  ctl_t             ctl_i,
  input  logic [MAG_W-1:0] big_i,
  input  logic [REM_W-1:0] rem_i,
  input  logic [R_W-1:0]   quo_i,
  output ctl_t             ctl_o,
  output logic [MAG_W-1:0] big_o,
  output logic [REM_W-1:0] rem_o,
  output logic [R_W-1:0]   quo_o
);

  logic             take;
  logic [REM_W-1:0] diff;
  logic [REM_W-1:0] rem_d;
  logic [R_W-1:0]   quo_d;
  ctl_t             ctl_q;
  logic [MAG_W-1:0] big_q;
  logic [REM_W-1:0] rem_q;
  logic [R_W-1:0]   quo_q;

  assign take  = rem_i >= {1'b0, big_i};
  assign diff  = take ? (rem_i - {1'b0, big_i}) : rem_i;
  // diff stays below big, so the top bit is free for the shift
  assign rem_d = {diff[REM_W-2:0], 1'b0};
  assign quo_d = {quo_i[R_W-2:0], take};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (en_i) begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      big_q <= big_i;
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign ctl_o = ctl_q;
  assign big_o = big_q;
  assign rem_o = rem_q;
  assign quo_o = quo_q;

endmodule

// ===== rtl/core/a2p_mac_cell.sv =====
// Multiply-accumulate cell: acc * operand in Q30, floor, plus coefficient; two stages.
module a2p_mac_cell
  import a2p_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  ctl_t                    ctl_i,
  input  aux_t                    aux_i,
  input  logic signed [ACC_W-1:0] acc_i,
  input  logic [R_W-1:0]          mul_i,
  input  logic signed [ACC_W-1:0] coef_i,
  output ctl_t                    ctl_o,
  output aux_t                    aux_o,
  output logic signed [ACC_W-1:0] acc_o
);

  logic signed [PROD_W-1:0] prod_d;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [ACC_W-1:0]  acc_d;
  logic signed [ACC_W-1:0]  acc_q;
  ctl_t                     ctl1_q;
  ctl_t                     ctl2_q;
  aux_t                     aux1_q;
  aux_t                     aux2_q;

  assign prod_d = acc_i * $signed({1'b0, mul_i});
  // arithmetic shift by QB is the floor; the low ACC_W bits hold the result
  assign acc_d  = $signed(prod_q[QB +: ACC_W]) + coef_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl1_q <= '0;
      ctl2_q <= '0;
    end else if (en_i) begin
      ctl1_q <= ctl_i;
      ctl2_q <= ctl1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
      aux1_q <= aux_i;
      acc_q  <= acc_d;
      aux2_q <= aux1_q;
    end
  end

  assign ctl_o = ctl2_q;
  assign aux_o = aux2_q;
  assign acc_o = acc_q;

endmodule

// ===== rtl/core/a2p_unfold.sv =====
// Octant unfold, rounding, sign and saturation of the polynomial result; two stages.
module a2p_unfold
  import a2p_pkg::*;
(
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  ctl_t                        ctl_i,
  input  logic signed [ACC_W-1:0]     v_i,
  output ctl_t                        ctl_o,
  output logic signed [OUT_WIDTH-1:0] angle_o
);

  logic signed [UNF_W-1:0]     v_ext;
  logic signed [UNF_W-1:0]     sel;
  logic [UNF_W-1:0]            u_d;
  logic [UNF_W-1:0]            u_q;
  logic [UNF_W-1:0]            sum;
  logic [UNF_W-1:0]            mag_full;
  logic [OUT_WIDTH:0]          mag_s;
  logic signed [OUT_WIDTH-1:0] angle_d;
  logic signed [OUT_WIDTH-1:0] angle_q;
  ctl_t                        ctl1_q;
  ctl_t                        ctl2_q;

  assign v_ext = {{(UNF_W - ACC_W){v_i[ACC_W-1]}}, v_i};

  // pi - (pi/2 - v) folds to pi/2 + v, so one add covers every octant
  always_comb begin
    if (ctl_i.ybig && ctl_i.xneg) begin
      sel = HALF_PI_Q30 + v_ext;
    end else if (ctl_i.ybig) begin
      sel = HALF_PI_Q30 - v_ext;
    end else if (ctl_i.xneg) begin
      sel = PI_Q30 - v_ext;
    end else begin
      sel = v_ext;
    end
  end

  assign u_d = sel[UNF_W-1] ? '0 : sel;

  assign sum      = u_q + RND;
  assign mag_full = sum >> SHIFT;
  assign mag_s    = (mag_full > MAG_LIM) ? MAG_LIM[OUT_WIDTH:0] : mag_full[OUT_WIDTH:0];

  always_comb begin
    if (ctl1_q.zero) begin
      angle_d = '0;
    end else if (ctl1_q.yneg) begin
      angle_d = $signed(OUT_WIDTH'(~mag_s + 1'b1));
    end else if (mag_s == MAG_LIM[OUT_WIDTH:0]) begin
      angle_d = OUT_WIDTH'(OUT_MAX);
    end else begin
      angle_d = $signed(mag_s[OUT_WIDTH-1:0]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl1_q <= '0;
      ctl2_q <= '0;
    end else if (en_i) begin
      ctl1_q <= ctl_i;
      ctl2_q <= ctl1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      u_q     <= u_d;
      angle_q <= angle_d;
    end
  end

  assign ctl_o   = ctl2_q;
  assign angle_o = angle_q;

endmodule

// ===== rtl/core/atan2_poly_approx_unit.sv =====
// Top level: pipelined four-quadrant atan2 built from division and multiply-add cells.
// Throughput: one transfer per cycle while in_stall_o is low, set by a fully pipelined
// row of 31 one-bit division cells, 8 two-stage multiply-add cells and a two-stage
// unfold stage.
// The output register plus a one-entry skid hold results while out_stall_i is high.
// Reset clears all valid flags; there is no memory and no clearing pass.
module atan2_poly_approx_unit
  import a2p_pkg::*;
(
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic signed [IN_WIDTH-1:0]  y_in_i,
  input  logic signed [IN_WIDTH-1:0]  x_in_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic signed [OUT_WIDTH-1:0] angle_o
);

  // Pipeline advance: every cell moves on unless the skid entry is occupied.
  logic en;

  // Input stage: magnitudes, octant flags, and the min/max swap.
  logic             y_neg;
  logic             x_neg;
  logic [MAG_W-1:0] ay;
  logic [MAG_W-1:0] ax;
  logic             ybig;
  ctl_t             s0_ctl_d;
  ctl_t             s0_ctl_q;
  logic [MAG_W-1:0] s0_big_q;
  logic [MAG_W-1:0] s0_small_q;

  assign y_neg = y_in_i[IN_WIDTH-1];
  assign x_neg = x_in_i[IN_WIDTH-1];
  // Two's complement negate; the most negative value maps to 2^(IN_WIDTH-1) exactly.
  assign ay    = y_neg ? (MAG_W'(~y_in_i) + MAG_W'(1)) : MAG_W'(y_in_i);
  assign ax    = x_neg ? (MAG_W'(~x_in_i) + MAG_W'(1)) : MAG_W'(x_in_i);
  // Equal magnitudes keep the x-major branch, so the ratio is exactly one.
  assign ybig  = ay > ax;

  always_comb begin
    s0_ctl_d.valid = in_valid_i;
    s0_ctl_d.zero  = (ay == '0) && (ax == '0);
    s0_ctl_d.ybig  = ybig;
    s0_ctl_d.xneg  = x_neg;
    s0_ctl_d.yneg  = y_neg;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_ctl_q <= '0;
    end else if (en) begin
      s0_ctl_q <= s0_ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s0_big_q   <= ybig ? ay : ax;
      s0_small_q <= ybig ? ax : ay;
    end
  end

  // Division row: each cell resolves one bit of r = floor(small * 2^30 / big),
  // most significant first, and hands remainder and partial quotient on.
  ctl_t             dv_ctl [DIV_CELLS+1];
  logic [MAG_W-1:0] dv_big [DIV_CELLS+1];
  logic [REM_W-1:0] dv_rem [DIV_CELLS+1];
  logic [R_W-1:0]   dv_quo [DIV_CELLS+1];

  assign dv_ctl[0] = s0_ctl_q;
  assign dv_big[0] = s0_big_q;
  assign dv_rem[0] = {1'b0, s0_small_q};
  assign dv_quo[0] = '0;

  for (genvar k = 0; k < DIV_CELLS; k++) begin : g_div
    a2p_div_cell u_div_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .ctl_i  (dv_ctl[k]),
      .big_i  (dv_big[k]),
      .rem_i  (dv_rem[k]),
      .quo_i  (dv_quo[k]),
      .ctl_o  (dv_ctl[k+1]),
      .big_o  (dv_big[k+1]),
      .rem_o  (dv_rem[k+1]),
      .quo_o  (dv_quo[k+1])
    );
  end

  // Multiply-add row: cell 0 squares r, cells 1..POLY_N-1 run Horner's rule
  // on r^2, and the last cell multiplies the polynomial by r.
  ctl_t                    mc_ctl [MAC_CELLS];
  aux_t                    mc_aux [MAC_CELLS];
  logic signed [ACC_W-1:0] mc_acc [MAC_CELLS];

  for (genvar j = 0; j < MAC_CELLS; j++) begin : g_mac
    ctl_t                    ctl_in;
    aux_t                    aux_in;
    logic signed [ACC_W-1:0] acc_in;
    logic [R_W-1:0]          mul_in;
    logic signed [ACC_W-1:0] coef_in;

    if (j == 0) begin : g_square
      assign ctl_in    = dv_ctl[DIV_CELLS];
      assign aux_in.r  = dv_quo[DIV_CELLS];
      assign aux_in.r2 = '0;
      assign acc_in    = $signed({1'b0, dv_quo[DIV_CELLS]});
      assign mul_in    = dv_quo[DIV_CELLS];
      assign coef_in   = '0;
    end else if (j == 1) begin : g_first
      assign ctl_in    = mc_ctl[0];
      assign aux_in.r  = mc_aux[0].r;
      assign aux_in.r2 = mc_acc[0][R_W-1:0];
      assign acc_in    = COEF[0];
      assign mul_in    = mc_acc[0][R_W-1:0];
      assign coef_in   = COEF[j];
    end else if (j < MAC_CELLS - 1) begin : g_horner
      assign ctl_in    = mc_ctl[j-1];
      assign aux_in    = mc_aux[j-1];
      assign acc_in    = mc_acc[j-1];
      assign mul_in    = mc_aux[j-1].r2;
      assign coef_in   = COEF[j];
    end else begin : g_odd
      assign ctl_in    = mc_ctl[j-1];
      assign aux_in    = mc_aux[j-1];
      assign acc_in    = mc_acc[j-1];
      assign mul_in    = mc_aux[j-1].r;
      assign coef_in   = '0;
    end

    a2p_mac_cell u_mac_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .ctl_i  (ctl_in),
      .aux_i  (aux_in),
      .acc_i  (acc_in),
      .mul_i  (mul_in),
      .coef_i (coef_in),
      .ctl_o  (mc_ctl[j]),
      .aux_o  (mc_aux[j]),
      .acc_o  (mc_acc[j])
    );
  end

  // Unfold the octant, round to the output scale, apply the sign.
  ctl_t                        uf_ctl;
  logic signed [OUT_WIDTH-1:0] uf_angle;

  a2p_unfold u_unfold (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .ctl_i   (mc_ctl[MAC_CELLS-1]),
    .v_i     (mc_acc[MAC_CELLS-1]),
    .ctl_o   (uf_ctl),
    .angle_o (uf_angle)
  );

  // Output register and skid entry. The skid catches the one result that
  // leaves the pipeline in the cycle the output stalls; then hold the pipe.
  logic                        out_valid_d;
  logic                        out_valid_q;
  logic                        skid_valid_d;
  logic                        skid_valid_q;
  logic                        load_out_pipe;
  logic                        load_out_skid;
  logic                        load_skid;
  logic signed [OUT_WIDTH-1:0] out_angle_q;
  logic signed [OUT_WIDTH-1:0] skid_angle_q;

  assign en = !skid_valid_q;

  always_comb begin
    out_valid_d   = out_valid_q;
    skid_valid_d  = skid_valid_q;
    load_out_pipe = 1'b0;
    load_out_skid = 1'b0;
    load_skid     = 1'b0;
    if (skid_valid_q) begin
      // Drain the skid once the output transfer completes.
      if (!out_stall_i) begin
        load_out_skid = 1'b1;
        skid_valid_d  = 1'b0;
      end
    end else if (!out_valid_q || !out_stall_i) begin
      out_valid_d   = uf_ctl.valid;
      load_out_pipe = 1'b1;
    end else if (uf_ctl.valid) begin
      skid_valid_d = 1'b1;
      load_skid    = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out_skid) begin
      out_angle_q <= skid_angle_q;
    end else if (load_out_pipe) begin
      out_angle_q <= uf_angle;
    end
    if (load_skid) begin
      skid_angle_q <= uf_angle;
    end
  end

  assign in_stall_o  = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign angle_o     = out_angle_q;

  // The skid only ever holds a result behind a waiting output.
  a_skid_behind_out : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q
  ) else $error("skid entry occupied while the output register is empty");

  // The skid fills only after a stalled cycle.
  a_skid_fill_on_stall : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_valid_q) |-> $past(out_stall_i) && $past(out_valid_q)
  ) else $error("skid entry filled without an output stall");

  // The division row never yields a ratio above one.
  a_ratio_bound : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (dv_ctl[DIV_CELLS].valid && !dv_ctl[DIV_CELLS].zero)
      |-> (dv_quo[DIV_CELLS] <= (R_W'(1) << QB))
  ) else $error("quotient exceeds one in Q30");

  // Every delivered angle lies within plus or minus pi at the output scale.
  a_angle_range : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (int'(out_angle_q) <= ANGLE_BOUND) && (int'(out_angle_q) >= -ANGLE_BOUND - 1)
  ) else $error("angle outside the range of pi");

endmodule
